// ----- hdl/sli_pkg.sv -----
`default_nettype none

package sli_pkg;

  // Fixed widths of the narrow result fields.
  localparam int unsigned POS_W = 4;
  localparam int unsigned CNT_W = 5;

  // Register index of the configuration port.
  localparam int unsigned REG_SORT_ORDER = 0;

  // Sort order codes.
  localparam logic ORDER_ASCENDING  = 1'b0;
  localparam logic ORDER_DESCENDING = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // latch the new value and the current fill
    logic read;   // read the entry at the walk index
    logic step;   // settle one position, write it back and emit it
  } sli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the output register can take a result this cycle
    logic final_pos;   // the walk index is at the last position of this insert
  } sli_stat_t;

endpackage

`default_nettype wire

// ----- hdl/sli_ctrl.sv -----
`default_nettype none

module sli_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sli_pkg::sli_stat_t stat,
  output sli_pkg::sli_cmd_t      cmd
);
  import sli_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (stat.out_free) begin
          cmd.step  = 1'b1;
          state_nxt = stat.final_pos ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sli_datapath.sv -----
`default_nettype none

module sli_datapath #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned OUT_W      = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sli_pkg::sli_cmd_t       cmd,
  output sli_pkg::sli_stat_t           stat,
  input  wire logic                    sort_order,
  input  wire logic [DATA_WIDTH-1:0]   in_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OUT_W-1:0]             out_data,
  output logic                         out_dropped,
  output logic                         out_last
);
  import sli_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic signed [DATA_WIDTH-1:0] value_r;
  logic signed [DATA_WIDTH-1:0] carry_r;
  logic signed [DATA_WIDTH-1:0] rd_data_r;
  logic [CW-1:0]                held_r;
  logic [CW-1:0]                fill_r;
  logic [AW-1:0]                idx_r;
  logic                         placed_r;

  logic                         out_valid_r;
  logic [DATA_WIDTH-1:0]        out_value_r;
  logic [POS_W-1:0]             out_pos_r;
  logic [CNT_W-1:0]             out_cnt_r;
  logic                         out_dropped_r;
  logic                         out_last_r;

  logic                         full;
  logic [CW-1:0]                new_count;
  logic                         at_tail;
  logic                         passes;
  logic signed [DATA_WIDTH-1:0] settled;
  logic                         take_new;

  assign full      = (fill_r == CAP_C);
  assign new_count = full ? CAP_C : fill_r + CW'(1);
  assign at_tail   = (CW'(idx_r) == fill_r);
  assign passes    = (sort_order == ORDER_DESCENDING) ? (value_r < rd_data_r)
                                                      : (value_r > rd_data_r);
  assign take_new  = !at_tail && !placed_r && !passes;

  // Value that ends up at the current position.
  always_comb begin
    if (at_tail) begin
      settled = placed_r ? carry_r : value_r;
    end else if (placed_r) begin
      settled = carry_r;
    end else if (!passes) begin
      settled = value_r;
    end else begin
      settled = rd_data_r;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.final_pos = (CW'(idx_r) == new_count - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r <= mem[idx_r];
    end
    if (cmd.step) begin
      mem[idx_r] <= settled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      placed_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.start) begin
      placed_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.step) begin
      if (take_new) begin
        placed_r <= 1'b1;
      end
      if (stat.final_pos) begin
        held_r <= new_count;
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value_r <= in_value;
      fill_r  <= held_r;
    end
    if (cmd.step && (placed_r || take_new)) begin
      carry_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r   <= settled;
      out_pos_r     <= POS_W'(idx_r);
      out_cnt_r     <= CNT_W'(new_count);
      out_dropped_r <= full;
      out_last_r    <= stat.final_pos;
    end
  end

  always_comb begin
    out_data = '0;
    out_data[DATA_WIDTH+POS_W+CNT_W-1:0] = {out_cnt_r, out_pos_r, out_value_r};
  end

  assign out_valid   = out_valid_r;
  assign out_dropped = out_dropped_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/sorted_list_insert.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   tdata: value
// out_      master     out_tvalid/out_tready tdata: entry_value, entry_position,
//                                            entry_count; tuser: dropped;
//                                            tlast: last
// cfg_      APB slave  psel/penable/pready   sort_order at byte address 0
//
// Each accepted value walks the N entries held after the insert (at most
// CAPACITY), one position at a time. The single-port list memory sets this:
// every position takes a read step and then a settle-and-write step.
// Back-pressure on the output holds the walk in its settle step, one transfer
// per position. The output register lets the next value be accepted while the
// final result of the previous insert still waits to be taken. Reset is
// synchronous and active low; it empties the list and selects ascending order.

module sorted_list_insert #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: value
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  // tdata: entry_value, entry_position (4 bits), entry_count (5 bits)
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((DATA_WIDTH+9+7)/8)*8-1:0]        out_tdata,
  // tuser: dropped
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [2:0]                          cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);
  import sli_pkg::*;

  localparam int unsigned OUT_W = ((DATA_WIDTH + 9 + 7) / 8) * 8;

  sli_cmd_t  cmd;
  sli_stat_t stat;
  logic      sort_order_r;
  logic      reg_hit;

  // The register file has a single entry; bit 2 of the address tells it
  // apart from the first address beyond it.
  assign reg_hit    = (cfg_paddr[2] == 1'b0);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_order_r <= ORDER_ASCENDING;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      sort_order_r <= cfg_pwdata[0];
    end
  end

  // Reads return the register for any address with bit 2 clear and zero elsewhere.
  assign cfg_prdata = reg_hit ? {31'd0, sort_order_r} : 32'd0;

  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sli_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .sort_order  (sort_order_r),
    .in_value    (in_tdata[DATA_WIDTH-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_dropped (out_tuser),
    .out_last    (out_tlast)
  );

endmodule

`default_nettype wire
